### design/mipmap_box_downsample_unit_macros.svh
// assertion macros for the mip chain generator checker
// expects clk and rst_n in the scope of each use
`ifndef MIPMAP_BOX_DOWNSAMPLE_UNIT_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLE_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the next one
`define MBDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbdu check failed: next-cycle property");

// antecedent implies consequent in the same cycle
`define MBDU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbdu check failed: same-cycle property");

`endif

### design/mbdu_pkg.sv
// shared types and constants of the mip chain generator
// no dependencies
package mbdu_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_LEVELS = 12;
  localparam int NUM_CH         = 4;
  localparam int MAX_CHANNELS   = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  localparam logic [11:0] RST_WIDTH  = 12'd256;
  localparam logic [11:0] RST_HEIGHT = 12'd256;
  localparam logic [2:0]  RST_BPP    = 3'd4;

  typedef struct packed {
    logic [7:0] channel_3;
    logic [7:0] channel_2;
    logic [7:0] channel_1;
    logic [7:0] channel_0;
  } in_item_t;

  typedef struct packed {
    logic [3:0] mip_level;
    logic [9:0] column;
    logic [9:0] row;
    logic [7:0] average_0;
    logic [7:0] average_1;
    logic [7:0] average_2;
    logic [7:0] average_3;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [2:0]  bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic load;   // take the input item
    logic eval;   // step the current level
    logic take;   // finish a 2x2 block read back from the line store
    logic flush;  // send the held result as last of run
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic pend_v;
    logic out_free;
  } dp_stat_t;

endpackage

### design/mbdu_ctrl.sv
// controller state machine of the mip chain generator
// depends on mbdu_pkg
module mbdu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbdu_pkg::dp_stat_t st,
  output mbdu_pkg::dp_cmd_t  cmd
);
  import mbdu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LEVEL = 4'b0010,
    S_READ  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.eval = 1'b1;
        if (st.stop) state_nxt = st.pend_v ? S_FLUSH : S_IDLE;
        else state_nxt = S_READ;
      end
      S_READ: begin
        // a held result must leave before the new one takes its place
        if (!st.pend_v || st.out_free) begin
          cmd.take  = 1'b1;
          state_nxt = S_LEVEL;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### design/mbdu_datapath.sv
// datapath: level counters, left pixel holds, pair sum line store, result registers
// depends on mbdu_pkg
module mbdu_datapath #(
  parameter int MAX_WIDTH  = mbdu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mbdu_pkg::DEF_MAX_LEVELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbdu_pkg::cfg_t      cfg,
  input  logic                clr_cnt,
  input  mbdu_pkg::dp_cmd_t   cmd,
  output mbdu_pkg::dp_stat_t  st,
  input  mbdu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mbdu_pkg::out_item_t out_data
);
  import mbdu_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(MAX_WIDTH + 1);
  localparam int KW = $clog2(MAX_LEVELS);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int BW = $clog2(SW + 1);
  localparam int PW = 9 * NUM_CH;

  logic [AW-1:0] col_r [MAX_LEVELS];
  logic [AW-1:0] row_r [MAX_LEVELS];
  logic [31:0]   hold_r [MAX_LEVELS];
  logic [PW-1:0] mem [MAX_WIDTH];
  logic [PW-1:0] line_r;
  logic [NUM_CH-1:0][8:0] pair, pair_r;
  logic [NUM_CH-1:0][7:0] px_r, avg;
  logic [KW-1:0] k_r;
  logic [3:0]    lvl_r;
  logic [9:0]    tcol_r, trow_r;
  out_item_t     pend_r, out_r, res, flush_item;
  logic          pend_v_r, out_v_r;

  // frame geometry from the registers
  logic [SW-1:0] w_eff, h_eff, m_sz, wk, hk, wn, hn;
  logic [31:0]   w32, h32;
  logic [BW-1:0] blen;
  logic [LW-1:0] levels;
  logic [2:0]    nch;
  logic [NUM_CH-1:0] mask;

  always_comb begin
    w32   = 32'(cfg.image_width);
    h32   = 32'(cfg.image_height);
    w_eff = (w32 == 32'd0) ? SW'(1) : (w32 > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(w32);
    h_eff = (h32 == 32'd0) ? SW'(1) : (h32 > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(h32);
    m_sz  = (w_eff < h_eff) ? w_eff : h_eff;
    blen  = '0;
    for (int i = 0; i < SW; i++) begin
      if (m_sz[i]) blen = BW'(i + 1);
    end
    levels = (32'(blen) > 32'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(blen);
    nch    = (cfg.bytes_per_pixel > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : cfg.bytes_per_pixel;
    for (int i = 0; i < NUM_CH; i++) mask[i] = (3'(i) < nch);
  end

  // one level step
  logic [AW-1:0]  c, r;
  logic [KW:0]    kp1;
  logic [SW:0]    c1, r1;
  logic [31:0]    slot32;
  logic           last_lvl, edge_drop, slot_ok, do_hold, do_wr, do_rd;
  logic [AW-1:0]  addr;

  always_comb begin
    c        = col_r[k_r];
    r        = row_r[k_r];
    kp1      = (KW + 1)'(k_r) + (KW + 1)'(1);
    wk       = w_eff >> k_r;
    hk       = h_eff >> k_r;
    wn       = w_eff >> kp1;
    hn       = h_eff >> kp1;
    c1       = (SW + 1)'(c) + (SW + 1)'(1);
    r1       = (SW + 1)'(r) + (SW + 1)'(1);
    last_lvl = (32'(kp1) >= 32'(levels));
    edge_drop = ((SW + 1)'(c) >= ((SW + 1)'(wn) << 1)) ||
                ((SW + 1)'(r) >= ((SW + 1)'(hn) << 1));
    slot32   = 32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> k_r) + 32'(c >> 1);
    slot_ok  = slot32 < 32'(MAX_WIDTH);
    addr     = slot32[AW-1:0];
    do_hold  = !last_lvl && !edge_drop && !c[0];
    do_wr    = !last_lvl && !edge_drop && c[0] && slot_ok && !r[0];
    do_rd    = !last_lvl && !edge_drop && c[0] && slot_ok && r[0];
    for (int i = 0; i < NUM_CH; i++) begin
      pair[i] = 9'(hold_r[k_r][8*i +: 8]) + 9'(px_r[i]);
    end
  end

  always_comb begin
    logic [9:0] s;
    s = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      s      = 10'(line_r[9*i +: 9]) + 10'(pair_r[i]);
      avg[i] = mask[i] ? s[9:2] : 8'd0;
    end
    res.mip_level   = lvl_r;
    res.column      = tcol_r;
    res.row         = trow_r;
    res.average_0   = avg[0];
    res.average_1   = avg[1];
    res.average_2   = avg[2];
    res.average_3   = avg[3];
    res.last_of_run = 1'b0;
  end

  always_comb begin
    flush_item             = pend_r;
    flush_item.last_of_run = 1'b1;
  end

  assign st.stop     = !do_rd;
  assign st.pend_v   = pend_v_r;
  assign st.out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_cnt) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else if (cmd.eval) begin
      if (c1 >= (SW + 1)'(wk)) begin
        col_r[k_r] <= '0;
        row_r[k_r] <= (r1 >= (SW + 1)'(hk)) ? '0 : AW'(r1);
      end else begin
        col_r[k_r] <= AW'(c1);
      end
    end
  end

  // line store and per-level holds
  always_ff @(posedge clk) begin
    if (cmd.eval && do_wr) mem[addr] <= pair;
    if (cmd.eval && do_rd) line_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && do_hold) hold_r[k_r] <= px_r;
    if (cmd.load) begin
      px_r[0] <= mask[0] ? in_data.channel_0 : 8'd0;
      px_r[1] <= mask[1] ? in_data.channel_1 : 8'd0;
      px_r[2] <= mask[2] ? in_data.channel_2 : 8'd0;
      px_r[3] <= mask[3] ? in_data.channel_3 : 8'd0;
    end else if (cmd.take) begin
      px_r <= avg;
    end
    if (cmd.eval && do_rd) begin
      pair_r <= pair;
      lvl_r  <= 4'(kp1);
      tcol_r <= 10'(c >> 1);
      trow_r <= 10'(r >> 1);
    end
    if (cmd.take) pend_r <= res;
    if (cmd.take && pend_v_r) out_r <= pend_r;
    else if (cmd.flush) out_r <= flush_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) k_r <= '0;
      else if (cmd.take) k_r <= KW'(kp1);
      if (cmd.take) pend_v_r <= 1'b1;
      else if (cmd.flush) pend_v_r <= 1'b0;
      if ((cmd.take && pend_v_r) || cmd.flush) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### design/mipmap_box_downsample_unit.sv
// top level of the mip chain generator: register port, controller, datapath
// depends on mbdu_pkg, mbdu_ctrl, mbdu_datapath
//
//   channel   | direction | payload / handshake
//   in_       | input     | in_item_t, in_valid / in_ready
//   out_      | output    | out_item_t, out_valid / out_ready
//   cfg (apb) | input     | psel penable pwrite paddr pwdata, prdata, pready
//
// an item that makes no result passes the accept and a single level step; one with results passes
// the accept, a level step per visited level, a line store read per result and a flush
// last_of_run is known only when the run ends, so results trail by one
// a stalled out_ready holds the read and flush states; no new item until the run is out
// synchronous active-low reset; line store and pixel holds are not cleared
module mipmap_box_downsample_unit #(
  parameter int MAX_WIDTH  = mbdu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mbdu_pkg::DEF_MAX_LEVELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbdu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mbdu_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mbdu_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en, clr_cnt;
  dp_cmd_t  cmd;
  dp_stat_t st;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = 32'(cfg_r.image_width);
      REG_HEIGHT: prdata = 32'(cfg_r.image_height);
      REG_BPP:    prdata = 32'(cfg_r.bytes_per_pixel);
      default:    prdata = 32'd0;
    endcase
  end

  // an unknown index leaves the counters alone
  assign clr_cnt = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_BPP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= RST_WIDTH;
      cfg_r.image_height    <= RST_HEIGHT;
      cfg_r.bytes_per_pixel <= RST_BPP;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_r.image_width     <= pwdata[11:0];
        REG_HEIGHT: cfg_r.image_height    <= pwdata[11:0];
        REG_BPP:    cfg_r.bytes_per_pixel <= pwdata[2:0];
        default:    ;
      endcase
    end
  end

  mbdu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mbdu_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clr_cnt   (clr_cnt),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/mbdu_checker.sv
// port-level checker for the mip chain generator, bound to the top level
// depends on mbdu_pkg and mipmap_box_downsample_unit_macros.svh
`include "mipmap_box_downsample_unit_macros.svh"

module mbdu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbdu_pkg::out_item_t out_data,
  input logic                pready
);
  import mbdu_pkg::*;

  // a stalled result holds
  `MBDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // one item at a time
  `MBDU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // results always belong to a reduced level
  `MBDU_ASSERT_SAME(a_level_nonzero, out_valid, out_data.mip_level != 4'd0)
  // the register port never waits
  `MBDU_ASSERT_SAME(a_pready_high, 1'b1, pready)

endmodule

bind mipmap_box_downsample_unit mbdu_checker u_mbdu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

### bench/tb_top.sv
// self-checking bench for mipmap_box_downsample_unit: random and directed frames,
// mip results predicted in-bench and checked in order; depends on mbdu_pkg
module tb_top;
  import mbdu_pkg::*;

  localparam int LINE_DEPTH = 2048;
  localparam int LEVEL_DEPTH = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT = 60;
  localparam int RANDOM_ITEMS = 56;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mipmap_box_downsample_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow of the chain state
  logic [11:0] img_w;
  logic [11:0] img_h;
  logic [2:0]  img_bpp;
  logic [35:0] pair_line [LINE_DEPTH];
  logic [31:0] left_hold [LEVEL_DEPTH];
  int col_cnt [LEVEL_DEPTH];
  int row_cnt [LEVEL_DEPTH];

  in_item_t  pixel_q [$];
  out_item_t mip_q [$];
  int errors = 0;
  int pixels_sent = 0;
  int mips_seen = 0;
  int frames_run = 0;
  longint cycles = 0;

  function automatic void clear_levels();
    for (int k = 0; k < LEVEL_DEPTH; k++) begin
      col_cnt[k] = 0;
      row_cnt[k] = 0;
    end
  endfunction

  function automatic void shadow_write(logic [3:0] addr, logic [31:0] val);
    if (addr == {REG_WIDTH, 2'b00}) begin
      img_w = val[11:0];
    end else if (addr == {REG_HEIGHT, 2'b00}) begin
      img_h = val[11:0];
    end else if (addr == {REG_BPP, 2'b00}) begin
      img_bpp = val[2:0];
    end else begin
      return;
    end
    clear_levels();
  endfunction

  // push the mip pixels that one base pixel completes
  function automatic void predict_mips(in_item_t it);
    int w, h, nch, lv, m, wk, hk, c, r, wn, hn, slot, s;
    logic [7:0] px [4];
    logic [8:0] pair [4];
    logic [31:0] hold;
    logic [35:0] line;
    out_item_t res;
    out_item_t run [$];
    w = (img_w == 0) ? 1 : (img_w > LINE_DEPTH) ? LINE_DEPTH : img_w;
    h = (img_h == 0) ? 1 : (img_h > LINE_DEPTH) ? LINE_DEPTH : img_h;
    nch = (img_bpp > MAX_CHANNELS) ? MAX_CHANNELS : img_bpp;
    m = (w < h) ? w : h;
    lv = 0;
    while (m != 0) begin
      lv++;
      m = m >> 1;
    end
    if (lv > LEVEL_DEPTH) lv = LEVEL_DEPTH;
    px[0] = (nch > 0) ? it.channel_0 : 8'd0;
    px[1] = (nch > 1) ? it.channel_1 : 8'd0;
    px[2] = (nch > 2) ? it.channel_2 : 8'd0;
    px[3] = (nch > 3) ? it.channel_3 : 8'd0;
    for (int k = 0; k < lv; k++) begin
      wk = w >> k;
      hk = h >> k;
      c = col_cnt[k];
      r = row_cnt[k];
      if (c + 1 >= wk) begin
        col_cnt[k] = 0;
        row_cnt[k] = (r + 1 >= hk) ? 0 : r + 1;
      end else begin
        col_cnt[k] = c + 1;
      end
      if (k + 1 >= lv) break;
      wn = w >> (k + 1);
      hn = h >> (k + 1);
      if (c >= 2 * wn || r >= 2 * hn) break;
      if (c % 2 == 0) begin
        left_hold[k] = {px[3], px[2], px[1], px[0]};
        break;
      end
      hold = left_hold[k];
      for (int i = 0; i < 4; i++) pair[i] = hold[8*i +: 8] + px[i];
      slot = LINE_DEPTH - (LINE_DEPTH >> k) + (c >> 1);
      if (slot >= LINE_DEPTH) break;
      if (r % 2 == 0) begin
        pair_line[slot] = {pair[3], pair[2], pair[1], pair[0]};
        break;
      end
      line = pair_line[slot];
      for (int i = 0; i < 4; i++) begin
        s = line[9*i +: 9] + pair[i];
        px[i] = (i < nch) ? s[9:2] : 8'd0;
      end
      res.mip_level = 4'(k + 1);
      res.column = 10'(c >> 1);
      res.row = 10'(r >> 1);
      res.average_0 = px[0];
      res.average_1 = px[1];
      res.average_2 = px[2];
      res.average_3 = px[3];
      res.last_of_run = 1'b0;
      run.push_back(res);
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) mip_q.push_back(run[i]);
  endfunction

  // input side: bursts with random gaps
  logic in_ready_seen = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!in_valid || in_ready_seen) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: stall pattern in random stretches, from always free to mostly busy
  int stall_mode = 0;
  int stall_len = 0;
  always @(negedge clk) begin
    if (stall_len == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_len <= $urandom_range(4, 40);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    in_ready_seen = in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_mips(in_data);
      pixels_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      mips_seen++;
      if (mip_q.size() == 0) begin
        $error("unexpected mip result %p", out_data);
        errors++;
      end else begin
        want = mip_q.pop_front();
        if (out_data.mip_level !== want.mip_level) begin
          $error("mip_level exp %0d got %0d", want.mip_level, out_data.mip_level);
          errors++;
        end
        if (out_data.column !== want.column) begin
          $error("column exp %0d got %0d", want.column, out_data.column);
          errors++;
        end
        if (out_data.row !== want.row) begin
          $error("row exp %0d got %0d", want.row, out_data.row);
          errors++;
        end
        if (out_data.average_0 !== want.average_0) begin
          $error("average_0 exp %0d got %0d", want.average_0, out_data.average_0);
          errors++;
        end
        if (out_data.average_1 !== want.average_1) begin
          $error("average_1 exp %0d got %0d", want.average_1, out_data.average_1);
          errors++;
        end
        if (out_data.average_2 !== want.average_2) begin
          $error("average_2 exp %0d got %0d", want.average_2, out_data.average_2);
          errors++;
        end
        if (out_data.average_3 !== want.average_3) begin
          $error("average_3 exp %0d got %0d", want.average_3, out_data.average_3);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run exp %0d got %0d", want.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_write(addr, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int bpp);
    reg_write({REG_WIDTH, 2'b00}, w);
    reg_write({REG_HEIGHT, 2'b00}, h);
    reg_write({REG_BPP, 2'b00}, bpp);
    frames_run++;
  endtask

  task automatic add_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
    in_item_t it;
    it.channel_0 = c0;
    it.channel_1 = c1;
    it.channel_2 = c2;
    it.channel_3 = c3;
    pixel_q.push_back(it);
  endtask

  task automatic add_random(int n);
    repeat (n) add_pixel($urandom, $urandom, $urandom, $urandom);
  endtask

  // idle only once every queued item went in and every result came out
  task automatic settle();
    @(negedge clk);
    while (pixel_q.size() > 0 || in_valid || mip_q.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  initial begin
    int w, h, n;
    img_w = RST_WIDTH;
    img_h = RST_HEIGHT;
    img_bpp = RST_BPP;
    clear_levels();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes, first row only
    add_pixel(8'hff, 8'h00, 8'hff, 8'h00);
    add_random(3);
    settle();

    // two 2x2 blocks at both extremes of the byte range
    set_frame(2, 2, 4);
    repeat (4) add_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    add_pixel(8'h00, 8'hff, 8'h00, 8'hff);
    add_pixel(8'hff, 8'h00, 8'hff, 8'h00);
    add_pixel(8'h01, 8'h02, 8'h03, 8'h03);
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    settle();
    // unknown register mid-frame keeps the counters
    set_frame(4, 4, 7);
    add_random(6);
    settle();
    reg_write(ADDR_UNUSED, 32'hffff_ffff);
    add_random(10);
    settle();
    // zero channels, then single-level images
    set_frame(4, 4, 0);
    add_random(16);
    settle();
    set_frame(0, 0, 1);
    add_random(3);
    settle();
    set_frame(4095, 1, 2);
    add_random(3);
    settle();
    // widest line, clamped, start of the first row
    set_frame(4095, 2, 3);
    add_random(4);
    settle();

    // random frames, mostly complete, some cut short
    n = 0;
    while (n < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      set_frame(w, h, $urandom_range(0, 7));
      if (w < 1) w = 1;
      if (h < 1) h = 1;
      if ($urandom_range(0, 3) == 0) w = $urandom_range(1, w * h);
      else w = w * h * $urandom_range(1, 2);
      if (w > RANDOM_ITEMS - n) w = RANDOM_ITEMS - n;
      add_random(w);
      n += w;
      settle();
    end

    $display("%0d frame setups, %0d pixels in, %0d mip results checked",
             frames_run, pixels_sent, mips_seen);
    $display("sizes from one to 2048 wide, all channel counts, odd edges and wraps");
    if (errors == 0 && mip_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mbdu_pkg.sv
design/mbdu_ctrl.sv
design/mbdu_datapath.sv
design/mipmap_box_downsample_unit.sv
design/mbdu_checker.sv
bench/tb_top.sv
